@@ hw/rtl/fss_pkg.sv @@
// Shared widths and controller/datapath command and status types for the frame sorter.
package fss_pkg;

	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned PAY_W   = 32;
	localparam int unsigned ENTRY_W = SEQ_W + PAY_W;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;  // capture an accepted request
		logic place;      // write the held frame at the insert position
		logic move;       // shift the entry below the insert position up by one
		logic emit_rd;    // read the store at the emit index
		logic emit_load;  // load the output register from the store
		logic emit_next;  // output request taken, advance or finish the batch
	} fss_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;         // store holds the maximum number of frames
		logic pos_zero;     // insert position has reached the bottom
		logic key_greater;  // entry read back sorts after the held frame
		logic item_last;    // held frame closes the batch
		logic at_end;       // output register holds the batch's final frame
	} fss_sts_t;

endpackage

@@ hw/rtl/fss_in_if.sv @@
// Frame input channel: valid/ready handshake with the frame fields.
interface fss_in_if;
	import fss_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_num;
	logic [PAY_W-1:0] payload;
	logic             last_frame;

	modport source (output valid, seq_num, payload, last_frame, input ready);
	modport sink   (input valid, seq_num, payload, last_frame, output ready);

endinterface

@@ hw/rtl/fss_out_if.sv @@
// Sorted output channel: valid/ready handshake with the emitted frame fields.
interface fss_out_if;
	import fss_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] out_seq_num;
	logic [PAY_W-1:0] out_payload;
	logic             out_last;
	logic             overflow;

	modport source (output valid, out_seq_num, out_payload, out_last, overflow, input ready);
	modport sink   (input valid, out_seq_num, out_payload, out_last, overflow, output ready);

endinterface

@@ hw/rtl/fss_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module fss_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/fss_ctrl.sv @@
// Controller: sequences frame insertion into the sorted store and the batch readout.
module fss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fss_pkg::fss_sts_t sts,
	output fss_pkg::fss_cmd_t cmd
);
	import fss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_RD,
		S_SHIFT_CMP,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				// ready is still low in the first cycle after reset
				if (in_valid && in_ready) begin
					cmd.load_item = 1'b1;
					if (!sts.full) begin
						state_d = S_SHIFT_RD;
					end else if (in_last) begin
						state_d = S_EMIT_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				if (sts.pos_zero) begin
					cmd.place = 1'b1;
					state_d   = sts.item_last ? S_EMIT_RD : S_IDLE;
				end else begin
					state_d = S_SHIFT_CMP;
				end
			end
			S_SHIFT_CMP: begin
				if (sts.key_greater) begin
					cmd.move = 1'b1;
					state_d  = S_SHIFT_RD;
				end else begin
					cmd.place = 1'b1;
					state_d   = sts.item_last ? S_EMIT_RD : S_IDLE;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.emit_load = 1'b1;
				state_d       = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (out_ready) begin
					cmd.emit_next = 1'b1;
					state_d       = sts.at_end ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_ready  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			in_ready  <= (state_d == S_IDLE);
			out_valid <= (state_d == S_EMIT_OUT);
		end
	end

endmodule

@@ hw/rtl/fss_datapath.sv @@
// Datapath: sorted frame store, insert position, fill count and output register.
module fss_datapath #(
	parameter int unsigned MAX_FRAMES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fss_pkg::fss_cmd_t        cmd,
	output fss_pkg::fss_sts_t        sts,
	input  logic [fss_pkg::SEQ_W-1:0] in_seq_num,
	input  logic [fss_pkg::PAY_W-1:0] in_payload,
	input  logic                     in_last_frame,
	output logic [fss_pkg::SEQ_W-1:0] out_seq_num,
	output logic [fss_pkg::PAY_W-1:0] out_payload,
	output logic                     out_last,
	output logic                     overflow
);
	import fss_pkg::*;

	localparam int unsigned AW = $clog2(MAX_FRAMES);
	localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

	logic [CW-1:0]      count_q;
	logic               dropped_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      emit_idx_q;
	logic [SEQ_W-1:0]   key_q;
	logic [PAY_W-1:0]   word_q;
	logic               last_q;

	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [SEQ_W-1:0]   rd_key;
	logic               final_idx;

	assign rd_key    = ram_rdata[ENTRY_W-1 -: SEQ_W];
	assign final_idx = (CW'(emit_idx_q) + CW'(1)) == count_q;

	// Store port selection
	assign ram_we    = cmd.place | cmd.move;
	assign ram_wdata = cmd.move ? ram_rdata : {key_q, word_q};
	assign ram_raddr = cmd.emit_rd ? emit_idx_q : (pos_q - AW'(1));

	fss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_FRAMES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status back to the controller
	always_comb begin
		sts.full        = (count_q == CW'(MAX_FRAMES));
		sts.pos_zero    = (pos_q == '0);
		sts.key_greater = (rd_key > key_q);
		sts.item_last   = last_q;
		sts.at_end      = out_last;
	end

	// Fill count, drop flag, insert position and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			pos_q      <= '0;
			emit_idx_q <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				last_q <= in_last_frame;
				if (sts.full) begin
					dropped_q <= 1'b1;
				end else begin
					pos_q <= count_q[AW-1:0];
				end
			end
			if (cmd.move) begin
				pos_q <= pos_q - AW'(1);
			end
			if (cmd.place) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.emit_next) begin
				if (out_last) begin
					count_q    <= '0;
					dropped_q  <= 1'b0;
					emit_idx_q <= '0;
				end else begin
					emit_idx_q <= emit_idx_q + AW'(1);
				end
			end
		end
	end

	// Held frame and output register
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q  <= in_seq_num;
			word_q <= in_payload;
		end
		if (cmd.emit_load) begin
			out_seq_num <= rd_key;
			out_payload <= ram_rdata[PAY_W-1:0];
			out_last    <= final_idx;
			overflow    <= dropped_q;
		end
	end

	// The store never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAMES))
		else $error("fill count beyond capacity");

	// An entry is only shifted up from a position above the bottom
	a_move_above_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (pos_q != '0))
		else $error("shift attempted at the bottom of the store");

	// Taking the final request of a batch empties the store and clears the drop flag
	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_next && out_last) |=> (count_q == '0) && !dropped_q)
		else $error("batch state not cleared after final request");

endmodule

@@ hw/rtl/frame_sequence_sorter.sv @@
// Top level of the frame sorter: controller, datapath and channel wiring.
//
//  channel  | modport | payload                                         | role
//  ---------+---------+-------------------------------------------------+------------------
//  frames   | sink    | seq_num, payload, last_frame                    | incoming frames
//  sorted   | source  | out_seq_num, out_payload, out_last, overflow    | sorted batch out
//
// A frame is placed by shifting up each held frame with a greater sequence number,
// stopping at the bottom of the store; each shift step is a read then a write on
// the store's ports.
// Readout reads each request from the store and loads it into the output register.
// Reset clears the fill count, drop flag and controller; store contents need no clearing.
// Frames are not taken while a batch is being read out; a stalled request holds its fields.
module frame_sequence_sorter #(
	parameter int unsigned MAX_FRAMES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	fss_in_if.sink    frames,
	fss_out_if.source sorted
);
	import fss_pkg::*;

	fss_cmd_t cmd;
	fss_sts_t sts;

	fss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frames.valid),
		.in_last   (frames.last_frame),
		.in_ready  (frames.ready),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fss_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_seq_num    (frames.seq_num),
		.in_payload    (frames.payload),
		.in_last_frame (frames.last_frame),
		.out_seq_num   (sorted.out_seq_num),
		.out_payload   (sorted.out_payload),
		.out_last      (sorted.out_last),
		.overflow      (sorted.overflow)
	);

endmodule
